### design/i2cx_pkg.sv
// Shared types, widths, register indexes and reset values of the I2C expander byte reader.
package i2cx_pkg;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;
    localparam int InDataW  = 8;
    localparam int OutDataW = 24;
    localparam int StatusW  = 2;

    localparam logic [CfgIdxW-1:0] REG_MODULE_LIMIT  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_DEVICE_SELECT = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_LONG_WAIT     = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_SHORT_WAIT    = 2'd3;

    localparam logic [5:0]  RST_MODULE_LIMIT  = 6'd24;
    localparam logic [7:0]  RST_DEVICE_SELECT = 8'h43;
    localparam logic [15:0] RST_LONG_WAIT     = 16'd600;
    localparam logic [15:0] RST_SHORT_WAIT    = 16'd100;

    localparam logic [StatusW-1:0] ST_OK         = 2'd0;
    localparam logic [StatusW-1:0] ST_BAD_MODULE = 2'd1;
    localparam logic [StatusW-1:0] ST_NO_ACK     = 2'd2;

    typedef struct packed {
        logic [5:0]  module_limit;
        logic [7:0]  device_select;
        logic [15:0] long_wait_ticks;
        logic [15:0] short_wait_ticks;
    } t_cfg;

    typedef struct packed {
        logic       func;
        logic [4:0] module_req;
        logic       sda_in;
    } t_in;

    typedef struct packed {
        logic               scl_out;
        logic               sda_out;
        logic               drive_enable;
        logic [4:0]         module_select;
        logic               busy_res;
        logic               done_res;
        logic [StatusW-1:0] status;
        logic [7:0]         read_byte;
    } t_res;

endpackage

### design/i2cx_core.sv
// Sequencer state and combinational step logic of the I2C byte read.
module i2cx_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  i2cx_pkg::t_in  i_item,
    input  i2cx_pkg::t_cfg i_cfg,
    output i2cx_pkg::t_res o_res
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_START   = 3'd1;
    localparam logic [2:0] PH_WRITE   = 3'd2;
    localparam logic [2:0] PH_RELEASE = 3'd3;
    localparam logic [2:0] PH_ACKIN   = 3'd4;
    localparam logic [2:0] PH_READ    = 3'd5;
    localparam logic [2:0] PH_SENDACK = 3'd6;
    localparam logic [2:0] PH_STOP    = 3'd7;

    localparam logic [2:0] L_NONE = 3'b000;
    localparam logic [2:0] L_SDA  = 3'b001;
    localparam logic [2:0] L_SCL  = 3'b010;
    localparam logic [2:0] L_EN   = 3'b100;

    logic [2:0]  r_phase, n_phase;
    logic [2:0]  r_bit, n_bit;
    logic [1:0]  r_sub, n_sub;
    logic [15:0] r_wait, n_wait;
    logic [2:0]  r_line, n_line;
    logic [7:0]  r_shift, n_shift;
    logic [4:0]  r_module, n_module;

    logic        do_drive;
    logic [2:0]  drv_lines;
    logic [15:0] drv_wait;
    logic        done;
    logic [1:0]  st;
    logic        wbit;

    always_comb begin
        n_phase   = r_phase;
        n_bit     = r_bit;
        n_sub     = r_sub;
        n_wait    = r_wait;
        n_line    = r_line;
        n_shift   = r_shift;
        n_module  = r_module;
        do_drive  = 1'b0;
        drv_lines = L_NONE;
        drv_wait  = i_cfg.long_wait_ticks;
        done      = 1'b0;
        st        = i2cx_pkg::ST_OK;
        wbit      = i_cfg.device_select[r_bit];

        if (!i_item.func) begin
            if (r_phase == PH_IDLE) begin
                if ({1'b0, i_item.module_req} >= i_cfg.module_limit) begin
                    done = 1'b1;
                    st   = i2cx_pkg::ST_BAD_MODULE;
                end else begin
                    n_module  = i_item.module_req;
                    n_phase   = PH_START;
                    n_sub     = 2'd0;
                    n_bit     = 3'd7;
                    n_shift   = 8'd0;
                    do_drive  = 1'b1;
                    drv_lines = L_SDA | L_SCL | L_EN;
                end
            end
        end else if (r_phase != PH_IDLE) begin
            if (r_wait > 16'd1) begin
                n_wait = r_wait - 16'd1;
            end else begin
                n_wait = 16'd0;
                unique case (r_phase)
                    PH_START: begin
                        do_drive = 1'b1;
                        if (r_sub == 2'd0) begin
                            n_sub     = 2'd1;
                            drv_lines = L_SCL | L_EN;
                        end else begin
                            n_phase   = PH_WRITE;
                            n_bit     = 3'd7;
                            n_sub     = 2'd0;
                            drv_lines = L_EN;
                        end
                    end
                    PH_WRITE: begin
                        do_drive = 1'b1;
                        if (r_sub == 2'd0) begin
                            n_sub     = 2'd1;
                            drv_lines = L_EN | {2'b00, wbit};
                            drv_wait  = i_cfg.short_wait_ticks;
                        end else if (r_sub == 2'd1) begin
                            n_sub     = 2'd2;
                            drv_lines = L_EN | L_SCL | {2'b00, wbit};
                        end else if (r_bit == 3'd0) begin
                            n_phase   = PH_RELEASE;
                            n_sub     = 2'd0;
                            drv_lines = r_line & L_SDA;
                        end else begin
                            n_bit     = r_bit - 3'd1;
                            n_sub     = 2'd0;
                            drv_lines = L_EN | (r_line & L_SDA);
                        end
                    end
                    PH_RELEASE: begin
                        do_drive  = 1'b1;
                        n_phase   = PH_ACKIN;
                        n_sub     = 2'd0;
                        drv_lines = L_SCL;
                    end
                    PH_ACKIN: begin
                        if (r_sub == 2'd0) begin
                            do_drive  = 1'b1;
                            n_sub     = i_item.sda_in ? 2'd2 : 2'd1;
                            drv_lines = L_NONE;
                        end else if (r_sub == 2'd2) begin
                            n_phase = PH_IDLE;
                            n_sub   = 2'd0;
                            done    = 1'b1;
                            st      = i2cx_pkg::ST_NO_ACK;
                        end else begin
                            do_drive  = 1'b1;
                            n_phase   = PH_READ;
                            n_bit     = 3'd7;
                            n_sub     = 2'd0;
                            n_shift   = 8'd0;
                            drv_lines = L_SCL;
                        end
                    end
                    PH_READ: begin
                        do_drive = 1'b1;
                        if (r_sub == 2'd0) begin
                            n_shift   = {r_shift[6:0], i_item.sda_in};
                            n_sub     = 2'd1;
                            drv_lines = L_NONE;
                        end else if (r_bit == 3'd0) begin
                            n_phase   = PH_SENDACK;
                            n_sub     = 2'd0;
                            drv_lines = L_EN;
                            drv_wait  = i_cfg.short_wait_ticks;
                        end else begin
                            n_bit     = r_bit - 3'd1;
                            n_sub     = 2'd0;
                            drv_lines = L_SCL;
                        end
                    end
                    PH_SENDACK: begin
                        do_drive = 1'b1;
                        if (r_sub == 2'd0) begin
                            n_sub     = 2'd1;
                            drv_lines = L_EN | L_SCL;
                        end else if (r_sub == 2'd1) begin
                            n_sub     = 2'd2;
                            drv_lines = L_NONE;
                        end else begin
                            n_phase   = PH_STOP;
                            n_sub     = 2'd0;
                            drv_lines = L_EN | L_SCL;
                        end
                    end
                    PH_STOP: begin
                        if (r_sub == 2'd0) begin
                            do_drive  = 1'b1;
                            n_sub     = 2'd1;
                            drv_lines = L_EN | L_SCL | L_SDA;
                        end else begin
                            n_phase = PH_IDLE;
                            n_sub   = 2'd0;
                            done    = 1'b1;
                            st      = i2cx_pkg::ST_OK;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_sub   = 2'd0;
                    end
                endcase
            end
        end

        if (do_drive) begin
            n_line = drv_lines;
            n_wait = (drv_wait == 16'd0) ? 16'd1 : drv_wait;
        end

        o_res.scl_out       = n_line[1];
        o_res.sda_out       = n_line[0];
        o_res.drive_enable  = n_line[2];
        o_res.module_select = n_module;
        o_res.busy_res      = (n_phase != PH_IDLE);
        o_res.done_res      = done;
        o_res.status        = st;
        o_res.read_byte     = (done && st == i2cx_pkg::ST_OK) ? n_shift : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_bit    <= 3'd7;
            r_sub    <= 2'd0;
            r_wait   <= 16'd0;
            r_line   <= L_NONE;
            r_shift  <= 8'd0;
            r_module <= 5'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_bit    <= n_bit;
            r_sub    <= n_sub;
            r_wait   <= n_wait;
            r_line   <= n_line;
            r_shift  <= n_shift;
            r_module <= n_module;
        end
    end

endmodule

### design/i2c_expander_byte_reader.sv
// Top level: input stage, configuration registers, step logic and output register.
// An accepted transaction goes into the input register; its result is registered into the output register.
// Throughput: one transaction per cycle; while a result waits, the slave side takes one more
// transaction into the input register and then holds tready low until the result is taken.
// Reset is synchronous and active low; it empties both stages, releases the bus lines and
// restores the configuration registers to their defaults.
module i2c_expander_byte_reader (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // module_req [4:0], sda_in [5], zero [7:6]
    input  logic [i2cx_pkg::InDataW-1:0]  i_s_tdata,
    // func [0]
    input  logic [0:0]                    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // scl_out [0], sda_out [1], drive_enable [2], module_select [7:3], busy_res [8],
    // read_byte [16:9], zero [23:17]
    output logic [i2cx_pkg::OutDataW-1:0] o_m_tdata,
    // done_res
    output logic                          o_m_tlast,
    // status [1:0]
    output logic [i2cx_pkg::StatusW-1:0]  o_m_tuser,
    input  logic                          i_cfg_we,
    input  logic [i2cx_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [i2cx_pkg::CfgDataW-1:0] i_cfg_data
);

    i2cx_pkg::t_cfg r_cfg;
    i2cx_pkg::t_in  r_in;
    logic           r_in_valid;
    i2cx_pkg::t_res core_res;
    i2cx_pkg::t_res r_out;
    logic           r_out_valid;
    logic           step;
    logic           s_accept;

    assign step       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || step;
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.module_limit     <= i2cx_pkg::RST_MODULE_LIMIT;
            r_cfg.device_select    <= i2cx_pkg::RST_DEVICE_SELECT;
            r_cfg.long_wait_ticks  <= i2cx_pkg::RST_LONG_WAIT;
            r_cfg.short_wait_ticks <= i2cx_pkg::RST_SHORT_WAIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                i2cx_pkg::REG_MODULE_LIMIT:  r_cfg.module_limit     <= i_cfg_data[5:0];
                i2cx_pkg::REG_DEVICE_SELECT: r_cfg.device_select    <= i_cfg_data[7:0];
                i2cx_pkg::REG_LONG_WAIT:     r_cfg.long_wait_ticks  <= i_cfg_data;
                i2cx_pkg::REG_SHORT_WAIT:    r_cfg.short_wait_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in.func       <= i_s_tuser[0];
            r_in.module_req <= i_s_tdata[4:0];
            r_in.sda_in     <= i_s_tdata[5];
        end
    end

    i2cx_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out.read_byte, r_out.busy_res, r_out.module_select,
                         r_out.drive_enable, r_out.sda_out, r_out.scl_out};
    assign o_m_tlast  = r_out.done_res;
    assign o_m_tuser  = r_out.status;

endmodule

### design/i2cx_checker.sv
// Port-level checks of the I2C expander byte reader and their binding to the top level.
module i2cx_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [i2cx_pkg::OutDataW-1:0] o_m_tdata,
    input logic                          o_m_tlast,
    input logic [i2cx_pkg::StatusW-1:0]  o_m_tuser
);

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (o_m_tuser == i2cx_pkg::ST_OK))
        else $error("Nonzero status on a transaction that ends no request.");

    a_byte_only_on_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[16:9] != 8'd0)) |->
        (o_m_tlast && (o_m_tuser == i2cx_pkg::ST_OK)))
        else $error("Read byte shown outside a successful end of request.");

    a_idle_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> !o_m_tdata[8])
        else $error("Busy still set on the transaction that ends a request.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser)))
        else $error("Stalled output transaction changed or dropped.");

endmodule

bind i2c_expander_byte_reader i2cx_checker u_i2cx_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

### bench/i2cx_tb_pkg.sv
// Item kinds shared by the stimulus and the checker of the I2C expander byte reader bench.
package i2cx_tb_pkg;

    typedef enum logic {
        FN_READ_REQ = 1'b0,
        FN_TICK     = 1'b1
    } t_func;

endpackage

### bench/i2cx_read_scoreboard.sv
// Checker that predicts every result of the I2C expander byte reader and compares it.
module i2cx_read_scoreboard (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [i2cx_pkg::InDataW-1:0]  i_s_tdata,
    input  logic [0:0]                    i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [i2cx_pkg::OutDataW-1:0] i_m_tdata,
    input  logic                          i_m_tlast,
    input  logic [i2cx_pkg::StatusW-1:0]  i_m_tuser,
    input  logic                          i_cfg_we,
    input  logic [i2cx_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [i2cx_pkg::CfgDataW-1:0] i_cfg_data,
    output int                            o_mismatches,
    output int                            o_pending,
    output logic                          o_bus_busy
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] LN_SDA = 3'b001;
    localparam logic [2:0] LN_SCL = 3'b010;
    localparam logic [2:0] LN_EN  = 3'b100;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_START,
        SEQ_ADDR,
        SEQ_RELEASE,
        SEQ_ACK_IN,
        SEQ_DATA,
        SEQ_ACK_OUT,
        SEQ_STOP
    } t_seq;

    i2cx_pkg::t_cfg                cfg;
    t_seq                          seq;
    logic [2:0]                    bit_q;
    logic [1:0]                    sub_q;
    logic [15:0]                   wait_q;
    logic [2:0]                    line_q;
    logic [7:0]                    shift_q;
    logic [4:0]                    cur_mod;
    logic                          fin;
    logic [i2cx_pkg::StatusW-1:0]  fin_code;
    i2cx_pkg::t_res                bus_results_due[$];

    function automatic void set_lines(logic [2:0] lines, logic [15:0] w);
        line_q = lines;
        wait_q = (w == 16'd0) ? 16'd1 : w;
    endfunction

    function automatic void end_read(logic [i2cx_pkg::StatusW-1:0] code);
        seq      = SEQ_IDLE;
        sub_q    = 2'd0;
        wait_q   = 16'd0;
        fin      = 1'b1;
        fin_code = code;
    endfunction

    function automatic i2cx_pkg::t_res next_bus_result(i2cx_tb_pkg::t_func fn,
                                                       logic [4:0] mreq, logic sda);
        i2cx_pkg::t_res r;
        logic           b;
        logic [15:0]    lw;
        logic [15:0]    sw;
        lw       = cfg.long_wait_ticks;
        sw       = cfg.short_wait_ticks;
        fin      = 1'b0;
        fin_code = i2cx_pkg::ST_OK;
        if (fn == i2cx_tb_pkg::FN_READ_REQ) begin
            if (seq == SEQ_IDLE) begin
                if ({1'b0, mreq} >= cfg.module_limit) begin
                    fin      = 1'b1;
                    fin_code = i2cx_pkg::ST_BAD_MODULE;
                end else begin
                    cur_mod = mreq;
                    seq     = SEQ_START;
                    sub_q   = 2'd0;
                    bit_q   = 3'd7;
                    shift_q = 8'd0;
                    set_lines(LN_SDA | LN_SCL | LN_EN, lw);
                end
            end
        end else if (seq != SEQ_IDLE) begin
            if (wait_q > 16'd1) begin
                wait_q--;
            end else begin
                wait_q = 16'd0;
                b = cfg.device_select[bit_q];
                unique case (seq)
                    SEQ_START: begin
                        if (sub_q == 2'd0) begin
                            sub_q = 2'd1;
                            set_lines(LN_SCL | LN_EN, lw);
                        end else begin
                            seq   = SEQ_ADDR;
                            bit_q = 3'd7;
                            sub_q = 2'd0;
                            set_lines(LN_EN, lw);
                        end
                    end
                    SEQ_ADDR: begin
                        if (sub_q == 2'd0) begin
                            sub_q = 2'd1;
                            set_lines(LN_EN | {2'b00, b}, sw);
                        end else if (sub_q == 2'd1) begin
                            sub_q = 2'd2;
                            set_lines(LN_EN | LN_SCL | {2'b00, b}, lw);
                        end else if (bit_q == 3'd0) begin
                            seq   = SEQ_RELEASE;
                            sub_q = 2'd0;
                            set_lines(line_q & LN_SDA, lw);
                        end else begin
                            bit_q = bit_q - 3'd1;
                            sub_q = 2'd0;
                            set_lines(LN_EN | (line_q & LN_SDA), lw);
                        end
                    end
                    SEQ_RELEASE: begin
                        seq   = SEQ_ACK_IN;
                        sub_q = 2'd0;
                        set_lines(LN_SCL, lw);
                    end
                    SEQ_ACK_IN: begin
                        if (sub_q == 2'd0) begin
                            sub_q = sda ? 2'd2 : 2'd1;
                            set_lines(3'b000, lw);
                        end else if (sub_q == 2'd2) begin
                            end_read(i2cx_pkg::ST_NO_ACK);
                        end else begin
                            seq     = SEQ_DATA;
                            bit_q   = 3'd7;
                            sub_q   = 2'd0;
                            shift_q = 8'd0;
                            set_lines(LN_SCL, lw);
                        end
                    end
                    SEQ_DATA: begin
                        if (sub_q == 2'd0) begin
                            shift_q = {shift_q[6:0], sda};
                            sub_q   = 2'd1;
                            set_lines(3'b000, lw);
                        end else if (bit_q == 3'd0) begin
                            seq   = SEQ_ACK_OUT;
                            sub_q = 2'd0;
                            set_lines(LN_EN, sw);
                        end else begin
                            bit_q = bit_q - 3'd1;
                            sub_q = 2'd0;
                            set_lines(LN_SCL, lw);
                        end
                    end
                    SEQ_ACK_OUT: begin
                        if (sub_q == 2'd0) begin
                            sub_q = 2'd1;
                            set_lines(LN_EN | LN_SCL, lw);
                        end else if (sub_q == 2'd1) begin
                            sub_q = 2'd2;
                            set_lines(3'b000, lw);
                        end else begin
                            seq   = SEQ_STOP;
                            sub_q = 2'd0;
                            set_lines(LN_EN | LN_SCL, lw);
                        end
                    end
                    SEQ_STOP: begin
                        if (sub_q == 2'd0) begin
                            sub_q = 2'd1;
                            set_lines(LN_EN | LN_SCL | LN_SDA, lw);
                        end else begin
                            end_read(i2cx_pkg::ST_OK);
                        end
                    end
                    default: begin
                        seq    = SEQ_IDLE;
                        sub_q  = 2'd0;
                        wait_q = 16'd0;
                    end
                endcase
            end
        end
        r.scl_out       = line_q[1];
        r.sda_out       = line_q[0];
        r.drive_enable  = line_q[2];
        r.module_select = cur_mod;
        r.busy_res      = (seq != SEQ_IDLE);
        r.done_res      = fin;
        r.status        = fin ? fin_code : i2cx_pkg::ST_OK;
        r.read_byte     = (fin && fin_code == i2cx_pkg::ST_OK) ? shift_q : 8'd0;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        i2cx_pkg::t_res want;
        i2cx_pkg::t_res got;
        if (!i_rst_n) begin
            cfg.module_limit     = i2cx_pkg::RST_MODULE_LIMIT;
            cfg.device_select    = i2cx_pkg::RST_DEVICE_SELECT;
            cfg.long_wait_ticks  = i2cx_pkg::RST_LONG_WAIT;
            cfg.short_wait_ticks = i2cx_pkg::RST_SHORT_WAIT;
            seq                  = SEQ_IDLE;
            bit_q                = 3'd7;
            sub_q                = 2'd0;
            wait_q               = 16'd0;
            line_q               = 3'b000;
            shift_q              = 8'd0;
            cur_mod              = 5'd0;
            bus_results_due.delete();
            o_mismatches         = 0;
            o_pending            = 0;
            o_bus_busy           = 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    i2cx_pkg::REG_MODULE_LIMIT:  cfg.module_limit     = i_cfg_data[5:0];
                    i2cx_pkg::REG_DEVICE_SELECT: cfg.device_select    = i_cfg_data[7:0];
                    i2cx_pkg::REG_LONG_WAIT:     cfg.long_wait_ticks  = i_cfg_data;
                    i2cx_pkg::REG_SHORT_WAIT:    cfg.short_wait_ticks = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.scl_out       = i_m_tdata[0];
                got.sda_out       = i_m_tdata[1];
                got.drive_enable  = i_m_tdata[2];
                got.module_select = i_m_tdata[7:3];
                got.busy_res      = i_m_tdata[8];
                got.read_byte     = i_m_tdata[16:9];
                got.done_res      = i_m_tlast;
                got.status        = i_m_tuser;
                o_bus_busy        = got.busy_res;
                if (bus_results_due.size() == 0) begin
                    $error("result transaction arrived with no request or tick outstanding");
                    o_mismatches++;
                end else begin
                    want = bus_results_due.pop_front();
                    check_field("scl_out", want.scl_out, got.scl_out);
                    check_field("sda_out", want.sda_out, got.sda_out);
                    check_field("drive_enable", want.drive_enable, got.drive_enable);
                    check_field("module_select", want.module_select, got.module_select);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("status", want.status, got.status);
                    check_field("read_byte", want.read_byte, got.read_byte);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                bus_results_due.push_back(next_bus_result(
                    i2cx_tb_pkg::t_func'(i_s_tuser[0]), i_s_tdata[4:0], i_s_tdata[5]));
            end
            o_pending = bus_results_due.size();
        end
    end

endmodule

### bench/testbench.sv
// Top of the I2C expander byte reader bench: clock, reset, stimulus and the final verdict.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;
    localparam int ITEM_GOAL   = 350;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [i2cx_pkg::InDataW-1:0]  i_s_tdata;
    logic [0:0]                    i_s_tuser;
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [i2cx_pkg::OutDataW-1:0] o_m_tdata;
    logic                          o_m_tlast;
    logic [i2cx_pkg::StatusW-1:0]  o_m_tuser;
    logic                          i_cfg_we;
    logic [i2cx_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [i2cx_pkg::CfgDataW-1:0] i_cfg_data;

    int          mismatches;
    int          pending;
    logic        bus_busy;
    logic [8:0]  item_q[$];
    logic        item_taken;
    int          src_idle_pct;
    int          sink_idle_pct;
    int          sent_items;
    int          quiet_cycles;
    logic [5:0]  limit_set;
    logic [15:0] long_set;
    logic [15:0] short_set;

    i2c_expander_byte_reader uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    i2cx_read_scoreboard checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .i_m_tuser    (o_m_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_bus_busy   (bus_busy)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        item_taken <= i_s_tvalid && o_s_tready;
    end

    always @(negedge i_clk) begin
        if (!i_s_tvalid || item_taken) begin
            if (item_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                i_s_tvalid             <= 1'b1;
                {i_s_tuser, i_s_tdata} <= item_q.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int held(logic [15:0] w);
        return (w == 16'd0) ? 1 : int'(w);
    endfunction

    task automatic queue_item(i2cx_tb_pkg::t_func fn, logic [4:0] mreq, logic sda);
        item_q.push_back({fn, 2'b00, sda, mreq});
        sent_items++;
    endtask

    task automatic queue_tick();
        queue_item(i2cx_tb_pkg::FN_TICK, 5'($urandom_range(31)), 1'($urandom_range(1)));
    endtask

    task automatic drain_results();
        while (item_q.size() != 0 || i_s_tvalid || pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(logic [i2cx_pkg::CfgIdxW-1:0] idx,
                             logic [i2cx_pkg::CfgDataW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        unique case (idx)
            i2cx_pkg::REG_MODULE_LIMIT: limit_set = val[5:0];
            i2cx_pkg::REG_LONG_WAIT:    long_set  = val;
            i2cx_pkg::REG_SHORT_WAIT:   short_set = val;
            default: ;
        endcase
    endtask

    // Ticks the bus until the block reports it has gone back to idle, for at most 64 rounds.
    task automatic settle_idle();
        int rounds;
        drain_results();
        rounds = 0;
        while (bus_busy && rounds < 64) begin
            repeat (41 * held(long_set) + 9 * held(short_set)) queue_tick();
            drain_results();
            rounds++;
        end
    endtask

    // A full read whose acknowledge sample is steered; data bits stay random.
    task automatic run_read(logic [4:0] mreq);
        int   lp;
        int   sp;
        int   ack_at;
        int   total;
        logic ack_bit;
        settle_idle();
        lp      = held(long_set);
        sp      = held(short_set);
        ack_at  = 20 * lp + 8 * sp;
        ack_bit = ($urandom_range(99) < 15);
        total   = ack_bit ? ack_at + lp : 41 * lp + 9 * sp;
        queue_item(i2cx_tb_pkg::FN_READ_REQ, mreq, 1'($urandom_range(1)));
        for (int i = 1; i <= total; i++) begin
            if ($urandom_range(99) < 3) begin
                queue_item(i2cx_tb_pkg::FN_READ_REQ, 5'($urandom_range(31)),
                           1'($urandom_range(1)));
            end
            queue_item(i2cx_tb_pkg::FN_TICK, 5'($urandom_range(31)),
                       (i == ack_at) ? ack_bit : 1'($urandom_range(1)));
        end
        repeat ($urandom_range(2)) queue_tick();
    endtask

    // A read cut short, sometimes with a wait register rewritten midway.
    task automatic run_cut_read();
        int total;
        settle_idle();
        total = 41 * held(long_set) + 9 * held(short_set);
        queue_item(i2cx_tb_pkg::FN_READ_REQ, 5'($urandom_range(limit_set - 1)), 1'b0);
        repeat ($urandom_range(1, total - 1)) queue_tick();
        if ($urandom_range(1) == 1) begin
            drain_results();
            if ($urandom_range(1) == 1) begin
                write_reg(i2cx_pkg::REG_LONG_WAIT, 16'($urandom_range(0, 3)));
            end else begin
                write_reg(i2cx_pkg::REG_SHORT_WAIT, 16'($urandom_range(0, 3)));
            end
        end
        repeat ($urandom_range(5)) queue_tick();
    endtask

    task automatic reconfigure();
        int pick;
        drain_results();
        pick = $urandom_range(3);
        write_reg(i2cx_pkg::REG_MODULE_LIMIT, (pick == 0) ? 16'd1 : (pick == 1) ? 16'd32 :
                                              16'($urandom_range(1, 32)));
        pick = $urandom_range(3);
        write_reg(i2cx_pkg::REG_DEVICE_SELECT, (pick == 0) ? 16'd0 : (pick == 1) ? 16'd255 :
                                               16'($urandom_range(255)));
        write_reg(i2cx_pkg::REG_LONG_WAIT, 16'($urandom_range(0, 3)));
        write_reg(i2cx_pkg::REG_SHORT_WAIT, 16'($urandom_range(0, 3)));
    endtask

    task automatic push_noise();
        queue_item($urandom_range(1) ? i2cx_tb_pkg::FN_TICK : i2cx_tb_pkg::FN_READ_REQ,
                   5'($urandom_range(31)), 1'($urandom_range(1)));
    endtask

    initial begin
        int target;
        int pick;
        int base;
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = '0;
        i_m_tready    = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        item_taken    = 1'b0;
        quiet_cycles  = 0;
        sent_items    = 0;
        src_idle_pct  = 14;
        sink_idle_pct = 66;
        limit_set     = i2cx_pkg::RST_MODULE_LIMIT;
        long_set      = i2cx_pkg::RST_LONG_WAIT;
        short_set     = i2cx_pkg::RST_SHORT_WAIT;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_item(i2cx_tb_pkg::FN_TICK, 5'd31, 1'b1);
        queue_item(i2cx_tb_pkg::FN_READ_REQ, 5'd24, 1'b0);
        queue_item(i2cx_tb_pkg::FN_READ_REQ, 5'd31, 1'b1);
        drain_results();
        write_reg(i2cx_pkg::REG_LONG_WAIT, 16'd0);
        write_reg(i2cx_pkg::REG_SHORT_WAIT, 16'd0);
        queue_item(i2cx_tb_pkg::FN_READ_REQ, 5'd23, 1'b0);
        queue_item(i2cx_tb_pkg::FN_READ_REQ, 5'd0, 1'b1);
        repeat (3) queue_tick();
        settle_idle();
        write_reg(i2cx_pkg::REG_MODULE_LIMIT, 16'd32);
        write_reg(i2cx_pkg::REG_DEVICE_SELECT, 16'd255);
        run_read(5'd31);
        settle_idle();
        write_reg(i2cx_pkg::REG_MODULE_LIMIT, 16'd1);
        write_reg(i2cx_pkg::REG_DEVICE_SELECT, 16'd0);
        queue_item(i2cx_tb_pkg::FN_READ_REQ, 5'd1, 1'b0);
        run_read(5'd0);

        base = sent_items;
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct  = (ph == 0) ? 14 : (ph == 1) ? 66 : 0;
            sink_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 14 : 0;
            target = base + ((ITEM_GOAL - base) * (ph + 1)) / 3;
            while (sent_items < target) begin
                pick = $urandom_range(99);
                if (pick < 12) begin
                    reconfigure();
                end else if (pick < 72) begin
                    run_read(5'($urandom_range(limit_set - 1)));
                end else if (pick < 82) begin
                    run_cut_read();
                end else begin
                    repeat ($urandom_range(1, 6)) push_noise();
                end
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sim.f
design/i2cx_pkg.sv
design/i2cx_core.sv
design/i2c_expander_byte_reader.sv
design/i2cx_checker.sv
bench/i2cx_tb_pkg.sv
bench/i2cx_read_scoreboard.sv
bench/testbench.sv
